// ===== design/simt_warp_lane_alu_assert.svh =====
// ----------------------------------------------------------------------------
// SIMT warp lane ALU assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef SIMT_WARP_LANE_ALU_ASSERT_SVH
`define SIMT_WARP_LANE_ALU_ASSERT_SVH

// same-cycle implication
`define SWLA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/swla_pkg.sv =====
// ----------------------------------------------------------------------------
// SIMT warp lane ALU package
// Action codes, sequencer states and control bundles shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package swla_pkg;

   localparam int ACTION_W = 5;
   localparam int WARP_IDX_W = 3;
   localparam int REG_IDX_W = 5;
   localparam int LANE_IDX_W = 5;
   localparam int DATA_W = 32;
   localparam int MPID_W = 8;

   localparam logic [ACTION_W-1:0] ACT_NOP     = 5'd0;
   localparam logic [ACTION_W-1:0] ACT_MOV     = 5'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVI    = 5'd2;
   localparam logic [ACTION_W-1:0] ACT_LANEID  = 5'd3;
   localparam logic [ACTION_W-1:0] ACT_WARPID  = 5'd4;
   localparam logic [ACTION_W-1:0] ACT_CTAID   = 5'd5;
   localparam logic [ACTION_W-1:0] ACT_NTID    = 5'd6;
   localparam logic [ACTION_W-1:0] ACT_ADD     = 5'd7;
   localparam logic [ACTION_W-1:0] ACT_SUB     = 5'd8;
   localparam logic [ACTION_W-1:0] ACT_MUL     = 5'd9;
   localparam logic [ACTION_W-1:0] ACT_MAD     = 5'd10;
   localparam logic [ACTION_W-1:0] ACT_AND     = 5'd11;
   localparam logic [ACTION_W-1:0] ACT_OR      = 5'd12;
   localparam logic [ACTION_W-1:0] ACT_XOR     = 5'd13;
   localparam logic [ACTION_W-1:0] ACT_ADDI    = 5'd14;
   localparam logic [ACTION_W-1:0] ACT_SHL     = 5'd15;
   localparam logic [ACTION_W-1:0] ACT_SHR     = 5'd16;
   localparam logic [ACTION_W-1:0] ACT_SETP_EQ = 5'd17;
   localparam logic [ACTION_W-1:0] ACT_SETP_NE = 5'd18;
   localparam logic [ACTION_W-1:0] ACT_SETP_LT = 5'd19;
   localparam logic [ACTION_W-1:0] ACT_SETP_GE = 5'd20;
   localparam logic [ACTION_W-1:0] ACT_HOST    = 5'd21;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_LOAD,
      S_MUL,
      S_EXEC,
      S_HOST
   } state_type;

   // action, immediate and id values for the shared ALU
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   imm;
      logic [DATA_W-1:0]   lane_id;
      logic [DATA_W-1:0]   warp_id;
      logic [DATA_W-1:0]   cta_id;
      logic [DATA_W-1:0]   lane_count;
   } alu_ctl_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              pred;
   } alu_res_type;

   typedef struct packed {
      logic reg_en;
      logic pred_en;
   } wr_ctl_type;

endpackage

`default_nettype wire

// ===== design/swla_ifs.sv =====
// ----------------------------------------------------------------------------
// SIMT warp lane ALU channels
// Valid/ready channels for requests, lane results and the id register.
// ----------------------------------------------------------------------------
`default_nettype none

interface swla_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         action;
   logic [2:0]         warp_index;
   logic [4:0]         dst_reg;
   logic [4:0]         src_a_reg;
   logic [4:0]         src_b_reg;
   logic               src_b_used;
   logic [4:0]         src_c_reg;
   logic               src_c_used;
   logic signed [31:0] immediate;
   logic [31:0]        active_mask;
   logic [4:0]         host_lane;
   logic signed [31:0] host_value;

   modport source (
      output valid, action, warp_index, dst_reg, src_a_reg, src_b_reg, src_b_used,
             src_c_reg, src_c_used, immediate, active_mask, host_lane, host_value,
      input  ready
   );
   modport sink (
      input  valid, action, warp_index, dst_reg, src_a_reg, src_b_reg, src_b_used,
             src_c_reg, src_c_used, immediate, active_mask, host_lane, host_value,
      output ready
   );
endinterface

interface swla_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         lane_index;
   logic signed [31:0] lane_value;
   logic               lane_predicate;
   logic               lane_written;
   logic               last;

   modport source (
      output valid, lane_index, lane_value, lane_predicate, lane_written, last,
      input  ready
   );
   modport sink (
      input  valid, lane_index, lane_value, lane_predicate, lane_written, last,
      output ready
   );
endinterface

interface swla_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] multiprocessor_id;

   modport source (
      output valid, multiprocessor_id,
      input  ready
   );
   modport sink (
      input  valid, multiprocessor_id,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/swla_files.sv =====
// ----------------------------------------------------------------------------
// SIMT warp lane ALU register and predicate files
// Register file memory with two registered read ports and one write port,
// plus the predicate file memory.
// ----------------------------------------------------------------------------
`default_nettype none

module swla_files #(
   parameter int RF_DEPTH = 8192,
   parameter int PF_DEPTH = 2048,
   parameter int RF_AW = 13,
   parameter int PF_AW = 11
) (
   input  wire logic                     clock,
   input  wire logic [RF_AW-1:0]         rd_a_addr,
   input  wire logic [RF_AW-1:0]         rd_b_addr,
   output logic [swla_pkg::DATA_W-1:0]   rd_a_data,
   output logic [swla_pkg::DATA_W-1:0]   rd_b_data,
   input  wire swla_pkg::wr_ctl_type     wr_ctl,
   input  wire logic [RF_AW-1:0]         wr_reg_addr,
   input  wire logic [swla_pkg::DATA_W-1:0] wr_reg_data,
   input  wire logic [PF_AW-1:0]         wr_pred_addr,
   input  wire logic                     wr_pred_data
);
   import swla_pkg::*;

   logic [DATA_W-1:0] rf_mem [RF_DEPTH];
   logic              pf_mem [PF_DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_ctl.reg_en) begin
         rf_mem[wr_reg_addr] <= wr_reg_data;
      end
      rd_a_ff <= rf_mem[rd_a_addr];
      rd_b_ff <= rf_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.pred_en) begin
         pf_mem[wr_pred_addr] <= wr_pred_data;
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ===== design/swla_alu.sv =====
// ----------------------------------------------------------------------------
// SIMT warp lane ALU shared execution unit
// One lane operation per use; registered 32x32 multiplier feeds mul and mad.
// ----------------------------------------------------------------------------
`default_nettype none

module swla_alu (
   input  wire logic                        clock,
   input  wire logic                        mul_en,
   input  wire swla_pkg::alu_ctl_type       ctl,
   input  wire logic [swla_pkg::DATA_W-1:0] opnd_a,
   input  wire logic [swla_pkg::DATA_W-1:0] opnd_b,
   input  wire logic [swla_pkg::DATA_W-1:0] opnd_c,
   output swla_pkg::alu_res_type            res
);
   import swla_pkg::*;

   logic [DATA_W-1:0] product_ff;

   // low word of the product only; wraps at 32 bits
   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= DATA_W'(opnd_a * opnd_b);
      end
   end

   always_comb begin
      res = '0;
      case (ctl.action)
         ACT_MOV:     res.value = opnd_a;
         ACT_MOVI:    res.value = ctl.imm;
         ACT_LANEID:  res.value = ctl.lane_id;
         ACT_WARPID:  res.value = ctl.warp_id;
         ACT_CTAID:   res.value = ctl.cta_id;
         ACT_NTID:    res.value = ctl.lane_count;
         ACT_ADD:     res.value = opnd_a + opnd_b;
         ACT_SUB:     res.value = opnd_a - opnd_b;
         ACT_MUL:     res.value = product_ff;
         ACT_MAD:     res.value = product_ff + opnd_c;
         ACT_AND:     res.value = opnd_a & opnd_b;
         ACT_OR:      res.value = opnd_a | opnd_b;
         ACT_XOR:     res.value = opnd_a ^ opnd_b;
         ACT_ADDI:    res.value = opnd_a + ctl.imm;
         ACT_SHL:     res.value = opnd_a << ctl.imm[4:0];
         ACT_SHR:     res.value = opnd_a >> ctl.imm[4:0];
         ACT_SETP_EQ: res.pred = (opnd_a == opnd_b);
         ACT_SETP_NE: res.pred = (opnd_a != opnd_b);
         ACT_SETP_LT: res.pred = ($signed(opnd_a) < $signed(opnd_b));
         ACT_SETP_GE: res.pred = ($signed(opnd_a) >= $signed(opnd_b));
         default:     res = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/simt_warp_lane_alu.sv =====
// Sequencing: a request is taken in the idle state, then each lane walks read, load,
//   multiply and execute states in turn, execute holding while the result register is
//   full; a host write goes from idle to the host state, which holds likewise.
// Throughput: one lane at a time through the register file read pair and shared ALU.
// Reset (synchronous) clears control, then sweeps both files to zero one entry a
//   cycle, up to the depth of the deeper of the two files.
// ----------------------------------------------------------------------------
// SIMT warp lane ALU
// Sequencer around a shared ALU and per-warp, per-lane register and predicate
// files; emits one result per lane, or one for a host write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simt_warp_lane_alu_assert.svh"

module simt_warp_lane_alu #(
   parameter int LANES = 32,
   parameter int WARPS = 8,
   parameter int REGS = 32,
   parameter int PREDS = 8
) (
   input  wire logic   clock,
   input  wire logic   reset,
   swla_req_if.sink    req_ch,
   swla_rsp_if.source  rsp_ch,
   swla_csr_if.sink    csr_ch
);
   import swla_pkg::*;

   // file geometry: address = (warp * LANES + lane) * depth + index
   localparam int RF_DEPTH = WARPS * LANES * REGS;
   localparam int PF_DEPTH = WARPS * LANES * PREDS;
   localparam int CLR_DEPTH = (RF_DEPTH > PF_DEPTH) ? RF_DEPTH : PF_DEPTH;
   localparam int RF_AW = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
   localparam int PF_AW = (PF_DEPTH > 1) ? $clog2(PF_DEPTH) : 1;
   localparam int CLR_W = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
   localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int RF_WSTRIDE = LANES * REGS;
   localparam int PF_WSTRIDE = LANES * PREDS;

   // sequencer state
   state_type state_ff, state_in;
   logic [CLR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic [LANES-1:0]  mask_ff, mask_in;
   logic [MPID_W-1:0] mpid_ff, mpid_in;

   // request fields, held for the whole instruction
   logic [ACTION_W-1:0]   action_ff;
   logic [WARP_IDX_W-1:0] warp_ff;
   logic [REG_IDX_W-1:0]  dst_ff, ra_ff, rb_ff, rc_ff;
   logic                  bused_ff, cused_ff;
   logic [DATA_W-1:0]     imm_ff, hval_ff;
   logic [LANE_IDX_W-1:0] hlane_ff;

   // lane operands
   logic [DATA_W-1:0] opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic [DATA_W-1:0] opc_ff, opc_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LANE_IDX_W-1:0] rsp_lane_ff, rsp_lane_in;
   logic [DATA_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                  rsp_pred_ff, rsp_pred_in;
   logic                  rsp_written_ff, rsp_written_in;
   logic                  rsp_last_ff, rsp_last_in;

   // control decode
   logic req_accept;
   logic out_space;
   logic clr_done;
   logic lane_last;
   logic warp_ok, a_ok, b_ok, c_ok;
   logic lane_active, is_setp, lane_writes, host_ok;
   logic mul_en, rsp_load;

   // file ports
   logic [RF_AW-1:0]  a_addr, b_addr, c_addr, rd_a_addr, rd_b_addr;
   logic [RF_AW-1:0]  dst_addr, host_addr, wr_reg_addr;
   logic [PF_AW-1:0]  pdst_addr, wr_pred_addr;
   logic [DATA_W-1:0] rd_a_data, rd_b_data, wr_reg_data;
   logic              wr_pred_data;
   wr_ctl_type        wr_ctl;

   alu_ctl_type alu_ctl;
   alu_res_type alu_res;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign out_space  = !rsp_valid_ff || rsp_ch.ready;
   assign clr_done   = (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1));
   assign lane_last  = (lane_ff == LANE_W'(LANES - 1));

   // range checks: an out-of-range source reads as zero, an out-of-range
   // destination drops the store
   assign warp_ok = (32'(warp_ff) < WARPS);
   assign a_ok    = warp_ok && (32'(ra_ff) < REGS);
   assign b_ok    = warp_ok && bused_ff && (32'(rb_ff) < REGS);
   assign c_ok    = warp_ok && cused_ff && (32'(rc_ff) < REGS);
   assign host_ok = warp_ok && (32'(hlane_ff) < LANES) && (32'(dst_ff) < REGS);

   assign is_setp     = (action_ff inside {[ACT_SETP_EQ:ACT_SETP_GE]});
   assign lane_active = mask_ff[0] && (action_ff inside {[ACT_MOV:ACT_SETP_GE]});
   assign lane_writes = lane_active && warp_ok &&
                        (is_setp ? (32'(dst_ff) < PREDS) : (32'(dst_ff) < REGS));

   // constant-stride address math
   assign a_addr    = RF_AW'(32'(warp_ff) * RF_WSTRIDE + 32'(lane_ff) * REGS + 32'(ra_ff));
   assign b_addr    = RF_AW'(32'(warp_ff) * RF_WSTRIDE + 32'(lane_ff) * REGS + 32'(rb_ff));
   assign c_addr    = RF_AW'(32'(warp_ff) * RF_WSTRIDE + 32'(lane_ff) * REGS + 32'(rc_ff));
   assign dst_addr  = RF_AW'(32'(warp_ff) * RF_WSTRIDE + 32'(lane_ff) * REGS + 32'(dst_ff));
   assign host_addr = RF_AW'(32'(warp_ff) * RF_WSTRIDE + 32'(hlane_ff) * REGS + 32'(dst_ff));
   assign pdst_addr = PF_AW'(32'(warp_ff) * PF_WSTRIDE + 32'(lane_ff) * PREDS + 32'(dst_ff));

   // ALU control inputs: action, immediate and id values
   always_comb begin
      alu_ctl.action     = action_ff;
      alu_ctl.imm        = imm_ff;
      alu_ctl.lane_id    = DATA_W'(lane_ff);
      alu_ctl.warp_id    = 32'(mpid_ff) * WARPS + 32'(warp_ff);
      alu_ctl.cta_id     = DATA_W'(mpid_ff);
      alu_ctl.lane_count = DATA_W'(LANES);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = (req_ch.action == ACT_HOST) ? S_HOST : S_READ;
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: state_in = S_MUL;
         S_MUL:  state_in = S_EXEC;
         S_EXEC: begin
            if (out_space) begin
               state_in = lane_last ? S_IDLE : S_READ;
            end
         end
         S_HOST: begin
            if (out_space) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mul_en       = 1'b0;
      rsp_load     = 1'b0;
      rd_a_addr    = a_addr;
      rd_b_addr    = b_addr;
      wr_ctl       = '0;
      wr_reg_addr  = dst_addr;
      wr_reg_data  = alu_res.value;
      wr_pred_addr = pdst_addr;
      wr_pred_data = alu_res.pred;
      case (state_ff)
         S_CLEAR: begin
            // sweep both files to zero from one counter
            wr_ctl.reg_en  = (32'(clr_cnt_ff) < RF_DEPTH);
            wr_ctl.pred_en = (32'(clr_cnt_ff) < PF_DEPTH);
            wr_reg_addr    = RF_AW'(clr_cnt_ff);
            wr_reg_data    = '0;
            wr_pred_addr   = PF_AW'(clr_cnt_ff);
            wr_pred_data   = 1'b0;
         end
         S_IDLE: req_ch.ready = 1'b1;
         S_LOAD: rd_a_addr = c_addr;   // port a turns to operand c
         S_MUL:  mul_en = 1'b1;
         S_EXEC: begin
            // write back and present the lane only when the result register frees up
            rsp_load       = out_space;
            wr_ctl.reg_en  = out_space && lane_writes && !is_setp;
            wr_ctl.pred_en = out_space && lane_writes && is_setp;
         end
         S_HOST: begin
            rsp_load      = out_space;
            wr_ctl.reg_en = out_space && host_ok;
            wr_reg_addr   = host_addr;
            wr_reg_data   = hval_ff;
         end
         default: req_ch.ready = 1'b0;
      endcase
   end

   // register next values
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      lane_in    = lane_ff;
      mask_in    = mask_ff;
      mpid_in    = mpid_ff;
      opa_in     = opa_ff;
      opb_in     = opb_ff;
      opc_in     = opc_ff;

      if (state_ff == S_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + CLR_W'(1);
      end
      if (csr_ch.valid) begin
         mpid_in = csr_ch.multiprocessor_id;
      end
      if (req_accept) begin
         lane_in = '0;
         mask_in = LANES'(req_ch.active_mask);
      end
      if (state_ff == S_LOAD) begin
         // gate out-of-range and unused sources to zero
         opa_in = a_ok ? rd_a_data : '0;
         opb_in = b_ok ? rd_b_data : '0;
      end
      if (state_ff == S_MUL) begin
         opc_in = c_ok ? rd_a_data : '0;
      end
      if (state_ff == S_EXEC && out_space) begin
         lane_in = lane_ff + LANE_W'(1);
         mask_in = mask_ff >> 1;
      end

      // result register: hold while stalled, drop once taken
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_lane_in    = rsp_lane_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_pred_in    = rsp_pred_ff;
      rsp_written_in = rsp_written_ff;
      rsp_last_in    = rsp_last_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (state_ff == S_HOST) begin
            rsp_lane_in    = hlane_ff;
            rsp_value_in   = hval_ff;
            rsp_pred_in    = 1'b0;
            rsp_written_in = host_ok;
            rsp_last_in    = 1'b1;
         end else begin
            rsp_lane_in    = LANE_IDX_W'(lane_ff);
            rsp_value_in   = lane_active ? alu_res.value : '0;
            rsp_pred_in    = lane_active && alu_res.pred;
            rsp_written_in = lane_writes;
            rsp_last_in    = lane_last;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         lane_ff      <= '0;
         mpid_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         lane_ff      <= lane_in;
         mpid_ff      <= mpid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff <= req_ch.action;
         warp_ff   <= req_ch.warp_index;
         dst_ff    <= req_ch.dst_reg;
         ra_ff     <= req_ch.src_a_reg;
         rb_ff     <= req_ch.src_b_reg;
         bused_ff  <= req_ch.src_b_used;
         rc_ff     <= req_ch.src_c_reg;
         cused_ff  <= req_ch.src_c_used;
         imm_ff    <= req_ch.immediate;
         hlane_ff  <= req_ch.host_lane;
         hval_ff   <= req_ch.host_value;
      end
      mask_ff        <= mask_in;
      opa_ff         <= opa_in;
      opb_ff         <= opb_in;
      opc_ff         <= opc_in;
      rsp_lane_ff    <= rsp_lane_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_pred_ff    <= rsp_pred_in;
      rsp_written_ff <= rsp_written_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.lane_index     = rsp_lane_ff;
   assign rsp_ch.lane_value     = rsp_value_ff;
   assign rsp_ch.lane_predicate = rsp_pred_ff;
   assign rsp_ch.lane_written   = rsp_written_ff;
   assign rsp_ch.last           = rsp_last_ff;

   swla_files #(
      .RF_DEPTH (RF_DEPTH),
      .PF_DEPTH (PF_DEPTH),
      .RF_AW    (RF_AW),
      .PF_AW    (PF_AW)
   ) u_files (
      .clock        (clock),
      .rd_a_addr    (rd_a_addr),
      .rd_b_addr    (rd_b_addr),
      .rd_a_data    (rd_a_data),
      .rd_b_data    (rd_b_data),
      .wr_ctl       (wr_ctl),
      .wr_reg_addr  (wr_reg_addr),
      .wr_reg_data  (wr_reg_data),
      .wr_pred_addr (wr_pred_addr),
      .wr_pred_data (wr_pred_data)
   );

   swla_alu u_alu (
      .clock  (clock),
      .mul_en (mul_en),
      .ctl    (alu_ctl),
      .opnd_a (opa_ff),
      .opnd_b (opb_ff),
      .opnd_c (opc_ff),
      .res    (alu_res)
   );

   // no file write while waiting for a request
   `SWLA_ASSERT_IMPL(a_idle_no_write, clock, reset, state_ff == S_IDLE, !wr_ctl.reg_en && !wr_ctl.pred_en, "file written while idle")
   // nothing is reported during the clearing sweep
   `SWLA_ASSERT_IMPL(a_clear_no_rsp, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff, "result during clear")
   // a lane leaving execute always lands in the result register
   `SWLA_ASSERT_NEXT(a_exec_loads, clock, reset, state_ff == S_EXEC && out_space, rsp_valid_ff, "lane result lost")
   // a compare reports its outcome in the predicate only
   `SWLA_ASSERT_IMPL(a_pred_no_value, clock, reset, rsp_valid_ff && rsp_pred_ff, rsp_value_ff == '0, "predicate with value")

endmodule

`default_nettype wire

// ===== tb/swla_test_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIMT warp lane ALU test support
// Request and lane-result types, plus a ledger that mirrors the register and
// predicate files, predicts the lane results of each request and checks them.
// ----------------------------------------------------------------------------
package swla_test_pkg;
   import swla_pkg::*;

   localparam int NUM_LANES = 32;
   localparam int NUM_WARPS = 8;
   localparam int NUM_REGS = 32;
   localparam int NUM_PREDS = 8;

   // action codes with no operation behind them
   localparam logic [ACTION_W-1:0] ACT_SPARE_LOW = 5'd22;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HIGH = 5'd31;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [WARP_IDX_W-1:0] warp;
      logic [REG_IDX_W-1:0]  dst;
      logic [REG_IDX_W-1:0]  src_a;
      logic [REG_IDX_W-1:0]  src_b;
      logic                  b_used;
      logic [REG_IDX_W-1:0]  src_c;
      logic                  c_used;
      logic [DATA_W-1:0]     imm;
      logic [DATA_W-1:0]     mask;
      logic [LANE_IDX_W-1:0] host_lane;
      logic [DATA_W-1:0]     host_value;
   } lane_request_type;

   typedef struct packed {
      logic [LANE_IDX_W-1:0] lane;
      logic [DATA_W-1:0]     value;
      logic                  pred;
      logic                  written;
      logic                  last;
   } lane_result_type;

   class lane_ledger;
      logic [DATA_W-1:0] regs [NUM_WARPS][NUM_LANES][NUM_REGS];
      logic              preds [NUM_WARPS][NUM_LANES][NUM_PREDS];
      logic [MPID_W-1:0] mp_id;
      lane_result_type   lane_results [$];
      int                mismatches;
      int                checked;

      function new();
         foreach (regs[w, l, r]) regs[w][l][r] = '0;
         foreach (preds[w, l, p]) preds[w][l][p] = 1'b0;
         mp_id = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_mp_id(logic [MPID_W-1:0] id);
         mp_id = id;
      endfunction

      function int pending();
         return lane_results.size();
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      // update the mirrored files and queue the lane results of one request
      function void apply_instruction(lane_request_type rq);
         lane_result_type   res;
         logic [DATA_W-1:0] a, b, c, v;
         logic              p, w, is_setp, is_exec;
         if (rq.action == ACT_HOST) begin
            regs[rq.warp][rq.host_lane][rq.dst] = rq.host_value;
            res = '{lane: rq.host_lane, value: rq.host_value, pred: 1'b0,
                    written: 1'b1, last: 1'b1};
            lane_results = {lane_results, res};
            return;
         end
         is_setp = rq.action >= ACT_SETP_EQ && rq.action <= ACT_SETP_GE;
         is_exec = rq.action >= ACT_MOV && rq.action <= ACT_SETP_GE;
         for (int lane = 0; lane < NUM_LANES; lane++) begin
            a = regs[rq.warp][lane][rq.src_a];
            b = rq.b_used ? regs[rq.warp][lane][rq.src_b] : '0;
            c = rq.c_used ? regs[rq.warp][lane][rq.src_c] : '0;
            v = '0;
            p = 1'b0;
            w = 1'b0;
            if (is_exec && rq.mask[lane]) begin
               case (rq.action)
                  ACT_MOV:     v = a;
                  ACT_MOVI:    v = rq.imm;
                  ACT_LANEID:  v = lane;
                  ACT_WARPID: begin
                     v = mp_id;
                     v = v * NUM_WARPS + rq.warp;
                  end
                  ACT_CTAID:   v = mp_id;
                  ACT_NTID:    v = NUM_LANES;
                  ACT_ADD:     v = a + b;
                  ACT_SUB:     v = a - b;
                  ACT_MUL:     v = a * b;
                  ACT_MAD:     v = a * b + c;
                  ACT_AND:     v = a & b;
                  ACT_OR:      v = a | b;
                  ACT_XOR:     v = a ^ b;
                  ACT_ADDI:    v = a + rq.imm;
                  ACT_SHL:     v = a << rq.imm[4:0];
                  ACT_SHR:     v = a >> rq.imm[4:0];
                  ACT_SETP_EQ: p = (a == b);
                  ACT_SETP_NE: p = (a != b);
                  ACT_SETP_LT: p = ($signed(a) < $signed(b));
                  ACT_SETP_GE: p = ($signed(a) >= $signed(b));
                  default:     v = '0;
               endcase
               if (is_setp) begin
                  // predicates past the file still report the compare
                  if (rq.dst < NUM_PREDS) begin
                     preds[rq.warp][lane][rq.dst] = p;
                     w = 1'b1;
                  end
               end else begin
                  regs[rq.warp][lane][rq.dst] = v;
                  w = 1'b1;
               end
            end
            res = '{lane: 5'(lane), value: v, pred: p, written: w,
                    last: (lane == NUM_LANES - 1)};
            lane_results = {lane_results, res};
         end
      endfunction

      task match_lane_result(lane_result_type got);
         lane_result_type want;
         if (lane_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, lane %0d value %h",
                                      got.lane, got.value));
            return;
         end
         want = lane_results.pop_front();
         checked++;
         if (got.lane !== want.lane)
            report_mismatch($sformatf("lane_index %0d, want %0d", got.lane, want.lane));
         if (got.value !== want.value)
            report_mismatch($sformatf("lane %0d lane_value %h, want %h",
                                      want.lane, got.value, want.value));
         if (got.pred !== want.pred)
            report_mismatch($sformatf("lane %0d lane_predicate %b, want %b",
                                      want.lane, got.pred, want.pred));
         if (got.written !== want.written)
            report_mismatch($sformatf("lane %0d lane_written %b, want %b",
                                      want.lane, got.written, want.written));
         if (got.last !== want.last)
            report_mismatch($sformatf("lane %0d last %b, want %b",
                                      want.lane, got.last, want.last));
      endtask
   endclass

endpackage

// ===== tb/simt_warp_lane_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIMT warp lane ALU testbench
// Drives warp instructions and host writes under random idling on both
// channels, mirrors the register and predicate files in a ledger and checks
// every lane result in order, across several multiprocessor id settings.
// ----------------------------------------------------------------------------
module simt_warp_lane_alu_test;
   import swla_pkg::*;
   import swla_test_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 12;
   // watchdog limit on the whole run, the clearing sweep included
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RANDOM_PHASES = 3;
   localparam int REQUESTS_PER_PHASE = 28;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;

   logic         clock;
   logic         reset;
   int unsigned  cycle_count = 0;

   swla_req_if req_bus ();
   swla_rsp_if rsp_bus ();
   swla_csr_if csr_bus ();

   lane_ledger      ledger = new();
   lane_result_type seen_result;

   // request mix, for the closing summary
   int sent_total = 0;
   int host_total = 0;
   int setp_total = 0;
   int idle_total = 0;
   int id_settings = 0;

   // remaining zero-gap stretch for each side
   int send_calm = 0;
   int take_calm = 0;

   logic hold_start = 1'b0;
   logic holding = 1'b0;
   int   taken_count = 0;

   simt_warp_lane_alu uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: count every rising edge and give up at the limit.
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d lane results outstanding",
               cycle_count, ledger.pending());
      $display("end of test: mismatches");
      $finish;
   end

   // Mostly back-to-back, sometimes a short gap, rarely a long one; now and
   // then start a stretch with no idling at all.
   function automatic int pick_gap(ref int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm = $urandom_range(16, 64);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Long receiver hold-off, counted here so the sender keeps pushing into a
   // stalled block.
   initial begin
      wait (hold_start);
      holding = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      holding = 1'b0;
   end

   // Result side: drive ready at the falling edge, pick a fresh stall after
   // every taken result.
   initial begin
      int stall_left;
      int seen_taken;
      stall_left = 0;
      seen_taken = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (taken_count != seen_taken) begin
            seen_taken = taken_count;
            stall_left = pick_gap(take_calm);
         end
         if (holding || reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Sample results at the rising edge and match them against the ledger.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_result.lane = rsp_bus.lane_index;
         seen_result.value = rsp_bus.lane_value;
         seen_result.pred = rsp_bus.lane_predicate;
         seen_result.written = rsp_bus.lane_written;
         seen_result.last = rsp_bus.last;
         ledger.match_lane_result(seen_result);
         taken_count++;
      end
   end

   // Offer one request after a random gap; hold valid high on return so a
   // back-to-back request keeps it up without a glitch. Enter and leave at a
   // falling edge.
   task automatic drive_request(lane_request_type rq);
      int gap;
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= rq.action;
      req_bus.warp_index <= rq.warp;
      req_bus.dst_reg <= rq.dst;
      req_bus.src_a_reg <= rq.src_a;
      req_bus.src_b_reg <= rq.src_b;
      req_bus.src_b_used <= rq.b_used;
      req_bus.src_c_reg <= rq.src_c;
      req_bus.src_c_used <= rq.c_used;
      req_bus.immediate <= rq.imm;
      req_bus.active_mask <= rq.mask;
      req_bus.host_lane <= rq.host_lane;
      req_bus.host_value <= rq.host_value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ledger.apply_instruction(rq);
      sent_total++;
      if (rq.action == ACT_HOST)
         host_total++;
      else if (rq.action >= ACT_SETP_EQ && rq.action <= ACT_SETP_GE)
         setp_total++;
      else if (rq.action == ACT_NOP || rq.action > ACT_HOST)
         idle_total++;
      @(negedge clock);
   endtask

   // Write the id register only with the block idle: drop valid, drain every
   // outstanding lane result, then do the write.
   task automatic write_mp_id(logic [MPID_W-1:0] id);
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.multiprocessor_id <= id;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      ledger.set_mp_id(id);
      id_settings++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic lane_request_type make_op(logic [ACTION_W-1:0] act,
                                                logic [WARP_IDX_W-1:0] warp,
                                                logic [REG_IDX_W-1:0] dst,
                                                logic [REG_IDX_W-1:0] src_a,
                                                logic [REG_IDX_W-1:0] src_b,
                                                logic [REG_IDX_W-1:0] src_c,
                                                logic b_used, logic c_used,
                                                logic [DATA_W-1:0] imm,
                                                logic [DATA_W-1:0] mask);
      lane_request_type rq;
      rq = '0;
      rq.action = act;
      rq.warp = warp;
      rq.dst = dst;
      rq.src_a = src_a;
      rq.src_b = src_b;
      rq.src_c = src_c;
      rq.b_used = b_used;
      rq.c_used = c_used;
      rq.imm = imm;
      rq.mask = mask;
      return rq;
   endfunction

   function automatic lane_request_type make_host(logic [WARP_IDX_W-1:0] warp,
                                                  logic [LANE_IDX_W-1:0] lane,
                                                  logic [REG_IDX_W-1:0] dst,
                                                  logic [DATA_W-1:0] value);
      lane_request_type rq;
      rq = make_op(ACT_HOST, warp, dst, '0, '0, '0, 1'b0, 1'b0, '0, '0);
      rq.host_lane = lane;
      rq.host_value = value;
      return rq;
   endfunction

   // Bias register picks to a small working set so reads hit written values.
   function automatic logic [REG_IDX_W-1:0] pick_reg();
      return ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
   endfunction

   function automatic lane_request_type random_request();
      lane_request_type rq;
      int               roll;
      roll = $urandom_range(0, 99);
      rq.warp = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1))
                                           : 3'($urandom_range(0, 7));
      rq.dst = pick_reg();
      rq.src_a = pick_reg();
      rq.src_b = pick_reg();
      rq.src_c = pick_reg();
      rq.b_used = ($urandom_range(0, 9) != 0);
      rq.c_used = ($urandom_range(0, 9) != 0);
      rq.host_lane = 5'($urandom);
      rq.host_value = $urandom;
      case ($urandom_range(0, 5))
         0, 1, 2: rq.imm = $urandom;
         3:       rq.imm = $urandom_range(0, 63);
         4:       rq.imm = 32'h8000_0000;
         default: rq.imm = 32'h7fff_ffff;
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2:    rq.mask = '1;
         3, 4:       rq.mask = '0;
         5, 6, 7:    rq.mask = 32'd1 << $urandom_range(0, 31);
         default:    rq.mask = $urandom;
      endcase
      if (roll < 12) begin
         rq.action = ACT_HOST;
         if ($urandom_range(0, 3) == 0)
            rq.host_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (roll < 15) begin
         rq.action = ACT_NOP;
      end else if (roll < 18) begin
         rq.action = 5'($urandom_range(ACT_SPARE_LOW, ACT_SPARE_HIGH));
      end else begin
         rq.action = 5'($urandom_range(ACT_MOV, ACT_SETP_GE));
      end
      if (rq.action >= ACT_SETP_EQ && rq.action <= ACT_SETP_GE) begin
         // mostly in-range predicates; compare a register with itself at times
         rq.dst = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(8, 31))
                                              : 5'($urandom_range(0, 7));
         if ($urandom_range(0, 3) == 0) rq.src_b = rq.src_a;
      end
      return rq;
   endfunction

   // Directed opening: seed extreme values by host write, then run every
   // operation over them, plus nop, a spare code, empty and single-lane masks
   // and a compare into a predicate past the file.
   task automatic run_directed();
      drive_request(make_op(ACT_NOP, 3'd0, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_SPARE_HIGH, 3'd0, 5'd1, 5'd1, 5'd1, 5'd1, 1'b1, 1'b1,
                            '1, '1));
      drive_request(make_host(3'd0, 5'd0, 5'd1, 32'h7fff_ffff));
      drive_request(make_host(3'd0, 5'd31, 5'd1, 32'h8000_0000));
      drive_request(make_host(3'd7, 5'd17, 5'd31, 32'hffff_ffff));
      drive_request(make_op(ACT_LANEID, 3'd0, 5'd2, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_MOVI, 3'd0, 5'd3, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1,
                            32'h8000_0000, 32'h5555_5555));
      drive_request(make_op(ACT_MOV, 3'd7, 5'd4, 5'd31, 5'd0, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_ADD, 3'd0, 5'd5, 5'd1, 5'd3, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_ADD, 3'd0, 5'd6, 5'd1, 5'd2, 5'd0, 1'b0, 1'b1, '0, '1));
      drive_request(make_op(ACT_SUB, 3'd0, 5'd6, 5'd2, 5'd1, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_MUL, 3'd0, 5'd7, 5'd1, 5'd2, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_MAD, 3'd0, 5'd8, 5'd1, 5'd2, 5'd3, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_MAD, 3'd0, 5'd9, 5'd1, 5'd2, 5'd3, 1'b1, 1'b0, '0, '1));
      drive_request(make_op(ACT_AND, 3'd0, 5'd10, 5'd1, 5'd2, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_OR, 3'd0, 5'd11, 5'd1, 5'd3, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_XOR, 3'd0, 5'd12, 5'd1, 5'd2, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_ADDI, 3'd0, 5'd13, 5'd1, 5'd0, 5'd0, 1'b1, 1'b1,
                            32'h7fff_ffff, '1));
      // shift amounts wider than 5 bits keep only the low bits
      drive_request(make_op(ACT_SHL, 3'd0, 5'd14, 5'd1, 5'd0, 5'd0, 1'b1, 1'b1,
                            32'd33, '1));
      drive_request(make_op(ACT_SHR, 3'd0, 5'd15, 5'd3, 5'd0, 5'd0, 1'b1, 1'b1, '1, '1));
      drive_request(make_op(ACT_SETP_EQ, 3'd0, 5'd0, 5'd1, 5'd1, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_SETP_NE, 3'd0, 5'd7, 5'd1, 5'd2, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_SETP_LT, 3'd0, 5'd1, 5'd1, 5'd3, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_SETP_GE, 3'd0, 5'd31, 5'd1, 5'd3, 5'd0, 1'b1, 1'b1, '0, '1));
      drive_request(make_op(ACT_WARPID, 3'd7, 5'd30, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1,
                            '0, 32'h0000_0001));
      drive_request(make_op(ACT_CTAID, 3'd7, 5'd29, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1,
                            '0, 32'h8000_0000));
      drive_request(make_op(ACT_NTID, 3'd3, 5'd0, 5'd0, 5'd0, 5'd0, 1'b1, 1'b1, '0, '0));
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_NOP;
      req_bus.warp_index = '0;
      req_bus.dst_reg = '0;
      req_bus.src_a_reg = '0;
      req_bus.src_b_reg = '0;
      req_bus.src_b_used = 1'b0;
      req_bus.src_c_reg = '0;
      req_bus.src_c_used = 1'b0;
      req_bus.immediate = '0;
      req_bus.active_mask = '0;
      req_bus.host_lane = '0;
      req_bus.host_value = '0;
      csr_bus.valid = 1'b0;
      csr_bus.multiprocessor_id = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // top id first, with the directed set; the clearing sweep after reset
      // just shows up as a long wait on ready
      write_mp_id(8'd255);
      run_directed();

      // random phases at the low id, a mid id and a random one
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_mp_id(phase == 0 ? 8'd0 :
                     phase == 1 ? 8'($urandom_range(1, 254)) : 8'($urandom));
         for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
            if (phase == 1 && n == 4) hold_start = 1'b1;
            drive_request(random_request());
         end
      end

      // drop valid, drain, then watch a while for stray results
      req_bus.valid <= 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d host writes, %0d compares, %0d nop or spare,",
               sent_total, host_total, setp_total, idle_total);
      $display("under %0d id settings; %0d lane results checked, %0d mismatches",
               id_settings, ledger.checked, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/swla_pkg.sv
design/swla_ifs.sv
design/swla_files.sv
design/swla_alu.sv
design/simt_warp_lane_alu.sv
tb/swla_test_pkg.sv
tb/simt_warp_lane_alu_test.sv
